// ===== hw/rtl/dwtbcg_pkg.sv =====
// Shared types, constants and the coefficient decode for the DWT block gather.
// No dependencies; every other file of the block but dwtbcg_queue imports this package.
`default_nettype none

package dwtbcg_pkg;

  localparam int unsigned WidthW  = 13;
  localparam int unsigned HeightW = 10;
  localparam int unsigned CoordW  = 9;
  localparam int unsigned SpanW   = 10;
  localparam int unsigned PosW    = 12;
  localparam int unsigned AddrW   = 24;
  localparam int unsigned BlockW  = 18;
  localparam int unsigned SlotW   = 6;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned AcPerBlock = 63;
  localparam int unsigned FamilySize = 20;

  localparam logic [CfgIdxW-1:0] CfgImageWidth   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHeightBlocks = 1'b1;

  localparam logic [WidthW-1:0]  ImageWidthReset   = 13'd1024;
  localparam logic [WidthW-1:0]  MaxWidth          = 13'd4096;
  localparam logic [HeightW-1:0] HeightBlocksReset = 10'd128;
  localparam logic [HeightW-1:0] MaxHeightBlocks   = 10'd512;

  localparam logic [SlotW-1:0] LastCoeff = 6'd63;
  localparam logic [SlotW-1:0] Fam0Start = 6'd1;
  localparam logic [SlotW-1:0] Fam1Start = 6'd22;
  localparam logic [SlotW-1:0] Fam2Start = 6'd43;

  typedef enum logic [1:0] {
    KindDc,
    KindParent,
    KindMember
  } coeff_kind_e;

  typedef struct packed {
    logic [1:0] shift;
    logic [1:0] dr;
    logic [1:0] dc;
  } member_t;

  typedef struct packed {
    coeff_kind_e      kind;
    logic [1:0]       fam;
    member_t          pos;
    logic [SlotW-1:0] slot;
  } coeff_t;

  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [BlockW-1:0] blk;
  } queue_item_t;

  typedef struct packed {
    logic [WidthW-1:0]  width;
    logic [SpanW-1:0]   width_blocks;
    logic [HeightW-1:0] height_blocks;
  } cfg_t;

  localparam logic [SlotW-1:0] SlotOrder [AcPerBlock] = '{
    6'd0,  6'd3,  6'd4,  6'd5,  6'd6,  6'd15, 6'd16, 6'd17,
    6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd1,  6'd7,  6'd8,
    6'd9,  6'd10, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36,
    6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44,
    6'd45, 6'd46, 6'd2,  6'd11, 6'd12, 6'd13, 6'd14, 6'd47,
    6'd48, 6'd49, 6'd50, 6'd51, 6'd52, 6'd53, 6'd54, 6'd55,
    6'd56, 6'd57, 6'd58, 6'd59, 6'd60, 6'd61, 6'd62
  };

  localparam member_t Members [FamilySize] = '{
    '{2'd1, 2'd0, 2'd0}, '{2'd1, 2'd0, 2'd1}, '{2'd1, 2'd1, 2'd0}, '{2'd1, 2'd1, 2'd1},
    '{2'd2, 2'd0, 2'd0}, '{2'd2, 2'd0, 2'd1}, '{2'd2, 2'd1, 2'd0}, '{2'd2, 2'd1, 2'd1},
    '{2'd2, 2'd0, 2'd2}, '{2'd2, 2'd0, 2'd3}, '{2'd2, 2'd1, 2'd2}, '{2'd2, 2'd1, 2'd3},
    '{2'd2, 2'd2, 2'd0}, '{2'd2, 2'd2, 2'd1}, '{2'd2, 2'd3, 2'd0}, '{2'd2, 2'd3, 2'd1},
    '{2'd2, 2'd2, 2'd2}, '{2'd2, 2'd2, 2'd3}, '{2'd2, 2'd3, 2'd2}, '{2'd2, 2'd3, 2'd3}
  };

  // Maps the coefficient number within a block to its kind, family, offset and slot.
  function automatic coeff_t decode_coeff(input logic [SlotW-1:0] k);
    coeff_t           d;
    logic [SlotW-1:0] base;
    logic [SlotW-1:0] off;
    logic [SlotW-1:0] idx;
    d = '0;
    if (k >= Fam2Start) begin
      d.fam = 2'd2;
      base  = Fam2Start;
    end else if (k >= Fam1Start) begin
      d.fam = 2'd1;
      base  = Fam1Start;
    end else begin
      d.fam = 2'd0;
      base  = Fam0Start;
    end
    off = k - base;
    idx = k - 6'd1;
    if (k == '0) begin
      d.kind = KindDc;
      d.slot = '0;
    end else if (off == '0) begin
      d.kind = KindParent;
      d.slot = {4'd0, d.fam} + 6'd1;
    end else begin
      d.kind = KindMember;
      d.pos  = Members[5'(off - 6'd1)];
      d.slot = SlotOrder[idx] + 6'd1;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dwtbcg_if.sv =====
// Handshake channels of the DWT block gather: block requests in, coefficient beats out.
// Depends on dwtbcg_pkg for field widths.
`default_nettype none

interface dwtbcg_in_if import dwtbcg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] block_row;
  logic [CoordW-1:0] block_col;

  modport source (output valid, output block_row, output block_col, input ready);
  modport sink (input valid, input block_row, input block_col, output ready);
endinterface

interface dwtbcg_out_if import dwtbcg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [AddrW-1:0]  source_address;
  logic [BlockW-1:0] dest_block;
  logic [SlotW-1:0]  dest_slot;
  logic              last;

  modport source (output valid, output source_address, output dest_block,
                  output dest_slot, output last, input ready);
  modport sink (input valid, input source_address, input dest_block,
                input dest_slot, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dwt_block_coefficient_gather.sv =====
// A request passes the request queue, the coefficient counter and pipeline registers
// of the back end before its first beat appears. Throughput: 64 beats per block, one
// per cycle unless out_if.ready stalls, set by the coefficient counter; blocks follow
// with no gap when queued. Requests are taken during a block until the queue is full.
// Reset: image width 1024, height 128 blocks, queue and pipeline empty.
`default_nettype none

module dwt_block_coefficient_gather import dwtbcg_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WidthW-1:0]  cfg_data_i,
  dwtbcg_in_if.sink          in_if,
  dwtbcg_out_if.source       out_if
);

  cfg_t        cfg;
  logic        push_valid;
  logic        push_ready;
  queue_item_t push_item;
  logic        pop_valid;
  logic        pop_ready;
  queue_item_t pop_item;

  dwtbcg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_if        (in_if),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .cfg_o        (cfg)
  );

  dwtbcg_queue #(
    .Width ($bits(queue_item_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_item)
  );

  dwtbcg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_ready_o (pop_ready),
    .out_if      (out_if)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/dwtbcg_front.sv =====
// Front end: configuration registers, request intake and destination block index.
// Depends on dwtbcg_pkg and dwtbcg_in_if.
`default_nettype none

module dwtbcg_front import dwtbcg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WidthW-1:0]  cfg_data_i,
  dwtbcg_in_if.sink          in_if,
  input  logic               push_ready_i,
  output logic               push_valid_o,
  output queue_item_t        push_item_o,
  output cfg_t               cfg_o
);

  logic [WidthW-1:0]       width_q, width_d;
  logic [HeightW-1:0]      height_q, height_d;
  logic [HeightW-1:0]      height_wr;
  logic [SpanW-1:0]        width_blocks;
  logic [CoordW+SpanW-1:0] blk_prod;

  assign height_wr = cfg_data_i[HeightW-1:0];

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgImageWidth: begin
          width_d = (cfg_data_i > MaxWidth) ? MaxWidth : cfg_data_i;
        end
        CfgHeightBlocks: begin
          height_d = (height_wr > MaxHeightBlocks) ? MaxHeightBlocks : height_wr;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ImageWidthReset;
      height_q <= HeightBlocksReset;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign width_blocks = width_q[WidthW-1:3];

  assign blk_prod = {{SpanW{1'b0}}, in_if.block_row} * {{CoordW{1'b0}}, width_blocks};

  assign push_item_o.row = in_if.block_row;
  assign push_item_o.col = in_if.block_col;
  assign push_item_o.blk = BlockW'(blk_prod + {{SpanW{1'b0}}, in_if.block_col});
  assign push_valid_o    = in_if.valid;
  assign in_if.ready     = push_ready_i;

  assign cfg_o.width         = width_q;
  assign cfg_o.width_blocks  = width_blocks;
  assign cfg_o.height_blocks = height_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dwtbcg_queue.sv =====
// Small flop-based FIFO that decouples request intake from coefficient generation.
// No dependencies.
`default_nettype none

module dwtbcg_queue #(
  parameter int unsigned Width = 36,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != Full);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dwtbcg_back.sv =====
// Back end: steps through the 64 coefficients of a block and computes their addresses
// in a three-stage pipeline. Depends on dwtbcg_pkg and dwtbcg_out_if.
`default_nettype none

module dwtbcg_back import dwtbcg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        pop_valid_i,
  input  queue_item_t pop_item_i,
  output logic        pop_ready_o,
  dwtbcg_out_if.source out_if
);

  logic              gen_valid_q, gen_valid_d;
  logic [SlotW-1:0]  k_q, k_d;
  queue_item_t       item_q;

  logic              a_valid_q;
  logic [PosW-1:0]   a_rr_q, a_cc_q;
  logic [BlockW-1:0] a_blk_q;
  logic [SlotW-1:0]  a_slot_q;
  logic              a_last_q;

  logic              b_valid_q;
  logic [AddrW-1:0]  b_prod_q;
  logic [PosW-1:0]   b_cc_q;
  logic [BlockW-1:0] b_blk_q;
  logic [SlotW-1:0]  b_slot_q;
  logic              b_last_q;

  logic              out_valid_q;
  logic [AddrW-1:0]  out_addr_q;
  logic [BlockW-1:0] out_blk_q;
  logic [SlotW-1:0]  out_slot_q;
  logic              out_last_q;

  logic                  adv;
  logic                  gen_fire;
  logic                  gen_done;
  logic                  load;
  coeff_t                coeff;
  logic                  add_rows;
  logic                  add_cols;
  logic [SpanW-1:0]      pr;
  logic [SpanW-1:0]      pc;
  logic [PosW-1:0]       rr;
  logic [PosW-1:0]       cc;
  logic [PosW+WidthW-1:0] prod_full;

  assign adv      = !out_valid_q || out_if.ready;
  assign gen_fire = gen_valid_q && adv;
  assign gen_done = gen_fire && (k_q == LastCoeff);
  assign pop_ready_o = !gen_valid_q || gen_done;
  assign load     = pop_valid_i && pop_ready_o;

  always_comb begin
    gen_valid_d = gen_valid_q;
    k_d         = k_q;
    if (load) begin
      gen_valid_d = 1'b1;
      k_d         = '0;
    end else if (gen_fire) begin
      gen_valid_d = !gen_done;
      k_d         = k_q + 1'b1;
    end
  end

  assign coeff    = decode_coeff(k_q);
  assign add_rows = (coeff.kind != KindDc) && (coeff.fam != 2'd0);
  assign add_cols = (coeff.kind != KindDc) && (coeff.fam != 2'd1);
  assign pr = {1'b0, item_q.row} + (add_rows ? cfg_i.height_blocks : {HeightW{1'b0}});
  assign pc = {1'b0, item_q.col} + (add_cols ? cfg_i.width_blocks : {SpanW{1'b0}});
  assign rr = ({2'b00, pr} << coeff.pos.shift) + {{(PosW-2){1'b0}}, coeff.pos.dr};
  assign cc = ({2'b00, pc} << coeff.pos.shift) + {{(PosW-2){1'b0}}, coeff.pos.dc};

  assign prod_full = a_rr_q * cfg_i.width;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_valid_q <= 1'b0;
      k_q         <= '0;
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      gen_valid_q <= gen_valid_d;
      k_q         <= k_d;
      if (adv) begin
        a_valid_q   <= gen_valid_q;
        b_valid_q   <= a_valid_q;
        out_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= pop_item_i;
    end
    if (adv) begin
      a_rr_q     <= rr;
      a_cc_q     <= cc;
      a_blk_q    <= item_q.blk;
      a_slot_q   <= coeff.slot;
      a_last_q   <= (k_q == LastCoeff);
      b_prod_q   <= prod_full[AddrW-1:0];
      b_cc_q     <= a_cc_q;
      b_blk_q    <= a_blk_q;
      b_slot_q   <= a_slot_q;
      b_last_q   <= a_last_q;
      out_addr_q <= b_prod_q + {{(AddrW-PosW){1'b0}}, b_cc_q};
      out_blk_q  <= b_blk_q;
      out_slot_q <= b_slot_q;
      out_last_q <= b_last_q;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.source_address = out_addr_q;
  assign out_if.dest_block     = out_blk_q;
  assign out_if.dest_slot      = out_slot_q;
  assign out_if.last           = out_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dwtbcg_checker.sv =====
// Port-level checks of the DWT block gather, attached to the top level by bind.
// Depends on dwtbcg_pkg and dwt_block_coefficient_gather.
`default_nettype none

module dwtbcg_checker import dwtbcg_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [AddrW-1:0]  out_addr_i,
  input logic [BlockW-1:0] out_block_i,
  input logic [SlotW-1:0]  out_slot_i,
  input logic              out_last_i
);

  logic             in_beat;
  logic             out_beat;
  logic [SlotW-1:0] beat_cnt_q;
  logic [3:0]       pend_q;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_cnt_q <= '0;
      pend_q     <= '0;
    end else begin
      if (out_beat) begin
        beat_cnt_q <= beat_cnt_q + 1'b1;
      end
      pend_q <= pend_q + {3'd0, in_beat} - {3'd0, out_beat && out_last_i};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_addr_i)
      && $stable(out_block_i) && $stable(out_slot_i) && $stable(out_last_i))
    else $error("Stalled output beat changed.");

  a_last_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> (out_last_i == (beat_cnt_q == LastCoeff)))
    else $error("Last mark not on the 64th beat of a block.");

  a_dc_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && (beat_cnt_q == '0) |-> (out_slot_i == '0))
    else $error("First beat of a block is not the DC slot.");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pend_q != '0))
    else $error("Output beat without an outstanding request.");

endmodule

bind dwt_block_coefficient_gather dwtbcg_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_addr_i  (out_if.source_address),
  .out_block_i (out_if.dest_block),
  .out_slot_i  (out_if.dest_slot),
  .out_last_i  (out_if.last)
);

`default_nettype wire
